// File: hw/rtl/plcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plcw_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int ONLINE_SHIFT = 24;
	localparam int POS_W = 64;
	localparam int WGT_W = 26;

	typedef enum logic [2:0] {
		REG_ORIGIN_LON = 3'd0,
		REG_ORIGIN_LAT = 3'd1,
		REG_DIR_LON    = 3'd2,
		REG_DIR_LAT    = 3'd3,
		REG_WIND_SIGN  = 3'd4
	} reg_idx_t;

	// controller -> datapath commands
	typedef struct packed {
		logic xform_a;     // latch input, compute partial products
		logic xform_b;     // sum partial products into along/across
		logic store_first;
		logic edge_close;  // 1: current->first, 0: prev->current
		logic edge_load;   // latch edge endpoints
		logic mul_lo;      // multiply step: low partial products
		logic mul_hi;      // multiply step: high partial products
		logic div_start;
		logic commit_prev;
	} dp_cmd_t;

	typedef struct packed {
		logic s_le0;
		logic e_gt0;
		logic s_eq0;
		logic e_eq0;
		logic div_busy;
		logic close_hit;   // closing edge current->first yields an event
	} dp_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/plcw_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface plcw_vtx_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] vertex_lon;
	logic signed [CW-1:0] vertex_lat;
	logic first_vertex;
	logic last_vertex;
	modport source (output valid, vertex_lon, vertex_lat, first_vertex, last_vertex,
		input ready);
	modport sink (input valid, vertex_lon, vertex_lat, first_vertex, last_vertex,
		output ready);
endinterface

interface plcw_res_if;
	logic valid;
	logic ready;
	logic signed [63:0] crossing_pos;
	logic signed [25:0] weight_delta;
	logic polygon_end;
	modport source (output valid, crossing_pos, weight_delta, polygon_end, input ready);
	modport sink (input valid, crossing_pos, weight_delta, polygon_end, output ready);
endinterface

interface plcw_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/plcw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Radix-2 restoring divider: 128-bit magnitude by 64-bit, low 64 quotient bits.
module plcw_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] num,
	input  wire logic [63:0]  den,
	output logic              busy,
	output logic [63:0]       quo
);
	logic [127:0] num_q;
	logic [63:0]  rem_q;
	logic [63:0]  den_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic [64:0]  sh;
	logic [64:0]  diff;

	assign sh   = {rem_q, num_q[127]};
	assign diff = sh - {1'b0, den_q};
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd127) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo   <= {quo[62:0], 1'b1};
			end else begin
				rem_q <= sh[63:0];
				quo   <= {quo[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/plcw_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module plcw_dp #(
	parameter int COORD_BITS = plcw_pkg::COORD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_idx,
	input  wire logic [31:0]            cfg_data,
	input  wire logic [COORD_BITS-1:0]  vlon,
	input  wire logic [COORD_BITS-1:0]  vlat,
	input  wire plcw_pkg::dp_cmd_t      cmd,
	output plcw_pkg::dp_sts_t           sts,
	output logic signed [25:0]          dir_w,
	output logic [63:0]                 s_al,
	output logic [63:0]                 e_al,
	output logic [63:0]                 xpos
);
	logic [31:0] olon_q, olat_q, dlon_q, dlat_q;
	logic [1:0]  wsign_q;
	logic [63:0] prev_al_q, prev_ac_q, first_al_q, first_ac_q;
	logic [63:0] cur_al_q, cur_ac_q;
	logic signed [63:0] p_ap_q, p_bq_q, p_aq_q, p_bp_q;
	logic [COORD_BITS-1:0] pa_w, pb_w;
	logic signed [31:0] pa_s, pb_s, a_s, b_s;
	logic [63:0] s_al_q, s_ac_q, e_al_q, e_ac_q;
	logic [63:0] diff, amag, bmag, dmag;
	logic        up, psign;
	logic        c_le0, f_gt0;
	logic [31:0] m_x, m_y;
	logic [63:0] m_p;
	logic [127:0] prod_q;
	logic [1:0]  mstep_q;
	logic [127:0] sprod, numv, nabs;
	logic        nneg_q, dneg_q;
	logic [63:0] quo, qs;
	logic        busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olon_q <= '0; olat_q <= '0; dlon_q <= 32'd1; dlat_q <= '0; wsign_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				plcw_pkg::REG_ORIGIN_LON: olon_q <= cfg_data;
				plcw_pkg::REG_ORIGIN_LAT: olat_q <= cfg_data;
				plcw_pkg::REG_DIR_LON:    dlon_q <= cfg_data;
				plcw_pkg::REG_DIR_LAT:    dlat_q <= cfg_data;
				plcw_pkg::REG_WIND_SIGN:  wsign_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wsign_q)
			2'd0: dir_w = '0;
			2'd1: dir_w = 26'sd1;
			default: dir_w = -26'sd1;
		endcase
	end

	assign pa_w = vlon - olon_q[COORD_BITS-1:0];
	assign pb_w = vlat - olat_q[COORD_BITS-1:0];
	assign pa_s = 32'(signed'(pa_w));
	assign pb_s = 32'(signed'(pb_w));
	assign a_s  = signed'(dlon_q);
	assign b_s  = signed'(dlat_q);

	// transform: four 32x32 products, registered, then summed
	always_ff @(posedge clk) begin
		if (cmd.xform_a) begin
			p_ap_q <= a_s * pa_s;
			p_bq_q <= b_s * pb_s;
			p_aq_q <= a_s * pb_s;
			p_bp_q <= b_s * pa_s;
		end
		if (cmd.xform_b) begin
			cur_al_q <= p_ap_q + p_bq_q;
			cur_ac_q <= p_aq_q - p_bp_q;
		end
		if (cmd.edge_load) begin
			s_al_q <= cmd.edge_close ? cur_al_q : prev_al_q;
			s_ac_q <= cmd.edge_close ? cur_ac_q : prev_ac_q;
			e_al_q <= cmd.edge_close ? first_al_q : cur_al_q;
			e_ac_q <= cmd.edge_close ? first_ac_q : cur_ac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_al_q <= '0; prev_ac_q <= '0;
			first_al_q <= '0; first_ac_q <= '0;
		end else begin
			if (cmd.commit_prev) begin
				prev_al_q <= cur_al_q; prev_ac_q <= cur_ac_q;
			end
			if (cmd.store_first) begin
				first_al_q <= cur_al_q; first_ac_q <= cur_ac_q;
			end
		end
	end

	assign sts.s_le0 = s_ac_q[63] || (s_ac_q == '0);
	assign sts.e_gt0 = !e_ac_q[63] && (e_ac_q != '0);
	assign sts.s_eq0 = (s_ac_q == '0);
	assign sts.e_eq0 = (e_ac_q == '0);
	assign sts.div_busy = busy;

	// closing edge classified early so the previous edge knows if it ends the polygon
	assign c_le0 = cur_ac_q[63] || (cur_ac_q == '0);
	assign f_gt0 = !first_ac_q[63] && (first_ac_q != '0);
	assign sts.close_hit = (c_le0 == f_gt0) || ((cur_ac_q == '0) && (first_ac_q == '0));

	assign up    = sts.s_le0;
	assign diff  = e_al_q - s_al_q;
	assign psign = s_ac_q[63] ^ diff[63];
	assign amag  = s_ac_q[63] ? -s_ac_q : s_ac_q;
	assign bmag  = diff[63] ? -diff : diff;
	assign dmag  = up ? e_ac_q - s_ac_q : s_ac_q - e_ac_q;

	// 64x64 unsigned product over four 32x32 steps
	always_comb begin
		case (mstep_q)
			2'd0: begin m_x = amag[31:0];  m_y = bmag[31:0];  end
			2'd1: begin m_x = amag[63:32]; m_y = bmag[31:0];  end
			2'd2: begin m_x = amag[31:0];  m_y = bmag[63:32]; end
			default: begin m_x = amag[63:32]; m_y = bmag[63:32]; end
		endcase
	end
	assign m_p = {32'd0, m_x} * {32'd0, m_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mstep_q <= '0;
		else if (cmd.edge_load) mstep_q <= '0;
		else if (cmd.mul_lo || cmd.mul_hi) mstep_q <= mstep_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_load) prod_q <= '0;
		else if (cmd.mul_lo || cmd.mul_hi) begin
			case (mstep_q)
				2'd0: prod_q <= prod_q + {64'd0, m_p};
				2'd1, 2'd2: prod_q <= prod_q + {32'd0, m_p, 32'd0};
				default: prod_q <= prod_q + {m_p, 64'd0};
			endcase
		end
	end

	assign sprod = psign ? -prod_q : prod_q;
	assign numv  = sprod + (up ? -{65'd0, dmag[63:1]} : {65'd0, dmag[63:1]});
	assign nabs  = numv[127] ? -numv : numv;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			nneg_q <= numv[127];
			dneg_q <= up;
		end
	end

	plcw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(nabs), .den(dmag), .busy(busy), .quo(quo)
	);

	assign qs   = (nneg_q != dneg_q) ? -quo : quo;
	assign xpos = s_al_q + qs;
	assign s_al = s_al_q;
	assign e_al = e_al_q;
endmodule
`default_nettype wire

// File: hw/rtl/plcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module plcw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_first,
	input  wire logic               in_last,
	output logic                    in_ready,
	input  wire plcw_pkg::dp_sts_t  sts,
	output plcw_pkg::dp_cmd_t       cmd,
	input  wire logic signed [25:0] dir_w,
	input  wire logic [63:0]        s_al,
	input  wire logic [63:0]        e_al,
	input  wire logic [63:0]        xpos,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             out_pos,
	output logic signed [25:0]      out_wgt,
	output logic                    out_end
);
	typedef enum logic [3:0] {
		S_IDLE, S_XA, S_XB, S_LOAD, S_CLASS, S_MUL, S_DIVGO, S_DIV,
		S_EMIT, S_ONL2, S_NEXT, S_NONE
	} state_t;

	state_t state_q;
	logic first_q, last_q, close_q, emitted_q, div_wait_q, onl_q;
	logic [2:0] mcnt_q;
	logic [63:0] pend_pos_q;
	logic signed [25:0] pend_wgt_q;
	logic pend_end_q;
	logic signed [25:0] big;
	logic out_free;
	logic out_load;
	logic edge_end;

	assign big      = dir_w <<< plcw_pkg::ONLINE_SHIFT;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;
	assign out_load = ((state_q == S_EMIT) || (state_q == S_NONE)) && out_free;
	// last result of an edge ends the polygon unless the closing edge still has events
	assign edge_end = close_q || (last_q && !sts.close_hit);

	always_comb begin
		cmd = '0;
		cmd.xform_a     = (state_q == S_IDLE) && in_valid;
		cmd.xform_b     = (state_q == S_XA);
		cmd.store_first = (state_q == S_XB) && first_q;
		cmd.edge_load   = (state_q == S_LOAD);
		cmd.edge_close  = close_q;
		cmd.mul_lo      = (state_q == S_MUL) && mcnt_q[2:1] == 2'd0;
		cmd.mul_hi      = (state_q == S_MUL) && mcnt_q[2:1] == 2'd1;
		cmd.div_start   = (state_q == S_DIVGO);
		// previous point moves on once the prev->current edge has been latched
		cmd.commit_prev = ((state_q == S_XB) && first_q) || ((state_q == S_LOAD) && !close_q);
	end

	// pending result: one result at a time into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; first_q <= 1'b0; last_q <= 1'b0;
			close_q <= 1'b0; emitted_q <= 1'b0; mcnt_q <= '0; onl_q <= 1'b0;
			div_wait_q <= 1'b0; pend_pos_q <= '0; pend_wgt_q <= '0; pend_end_q <= 1'b0;
			out_pos <= '0; out_wgt <= '0; out_end <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					first_q <= in_first; last_q <= in_last; emitted_q <= 1'b0;
					state_q <= S_XA;
				end
				S_XA: state_q <= S_XB;
				S_XB: begin
					close_q <= first_q;
					if (first_q && !last_q) state_q <= S_IDLE;
					else state_q <= S_LOAD;
				end
				S_LOAD: state_q <= S_CLASS;
				S_CLASS: begin
					mcnt_q <= '0;
					if ((sts.s_le0 && sts.e_gt0) || (!sts.s_le0 && !sts.e_gt0))
						state_q <= S_MUL;
					else if (sts.s_eq0 && sts.e_eq0) begin
						pend_pos_q <= s_al; pend_wgt_q <= big; pend_end_q <= 1'b0;
						onl_q <= 1'b1; state_q <= S_EMIT;
					end else state_q <= S_NEXT;
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd3) state_q <= S_DIVGO;
				end
				S_DIVGO: begin div_wait_q <= 1'b1; state_q <= S_DIV; end
				S_DIV: begin
					div_wait_q <= 1'b0;
					if (!div_wait_q && !sts.div_busy) begin
						pend_pos_q <= xpos;
						pend_wgt_q <= sts.s_le0 ? dir_w : -dir_w;
						pend_end_q <= edge_end;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (out_free) begin
					out_pos <= pend_pos_q; out_wgt <= pend_wgt_q;
					out_end <= pend_end_q; emitted_q <= 1'b1;
					if (onl_q) begin
						onl_q <= 1'b0; state_q <= S_ONL2;
					end else state_q <= S_NEXT;
				end
				// second half of on-line pair
				S_ONL2: begin
					pend_pos_q <= e_al; pend_wgt_q <= -big; pend_end_q <= edge_end;
					state_q <= S_EMIT;
				end
				S_NEXT: begin
					if (!close_q && last_q) begin
						close_q <= 1'b1; state_q <= S_LOAD;
					end else if (close_q && !emitted_q) state_q <= S_NONE;
					else state_q <= S_IDLE;
				end
				S_NONE: if (out_free) begin
					out_pos <= '0; out_wgt <= '0; out_end <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/polygon_line_crossing_winding_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Polygon line-crossing winding events. Vertices arrive one per transfer on
// vtx; each is offset by the origin, rotated by the direction vector into
// 64-bit along/across coordinates, and every edge crossing the line yields a
// transfer on res (position, winding delta, polygon_end on the polygon's last
// result). One vertex is handled at a time. A first vertex that does not close
// its polygon is only transformed and stored; any other vertex has one edge
// classified, a last vertex that is not also first has its closing edge
// classified as well, and a last vertex without events sends an empty end
// marker. Each crossing goes through a four-step 32x32 multiply, a divider
// start, the bit-serial 128/64 divider (one quotient bit per cycle) and the
// output register. An on-line edge yields two results. A result waits in the
// output register while res is stalled, and the block waits with it.
// Configuration writes on cfg are taken any time and belong only to idle
// periods.
module polygon_line_crossing_winding_top #(
	parameter int COORD_BITS = plcw_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	plcw_cfg_if.sink             cfg,
	plcw_vtx_if.sink             vtx,
	plcw_res_if.source           res
);
	plcw_pkg::dp_cmd_t cmd;
	plcw_pkg::dp_sts_t sts;
	logic signed [25:0] dir_w;
	logic [63:0] s_al, e_al, xpos, pos;

	assign cfg.ready = 1'b1;
	assign res.crossing_pos = pos;

	plcw_dp #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
		.vlon(vtx.vertex_lon[COORD_BITS-1:0]), .vlat(vtx.vertex_lat[COORD_BITS-1:0]),
		.cmd(cmd), .sts(sts), .dir_w(dir_w), .s_al(s_al), .e_al(e_al), .xpos(xpos)
	);

	plcw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vtx.valid), .in_first(vtx.first_vertex), .in_last(vtx.last_vertex),
		.in_ready(vtx.ready), .sts(sts), .cmd(cmd), .dir_w(dir_w),
		.s_al(s_al), .e_al(e_al), .xpos(xpos),
		.out_valid(res.valid), .out_ready(res.ready), .out_pos(pos),
		.out_wgt(res.weight_delta), .out_end(res.polygon_end)
	);
endmodule
`default_nettype wire

// File: tb/polygon_line_crossing_winding_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the polygon/line crossing block: vertex transfers
// go in, crossing events come out and are compared against an in-bench
// model of the transform, edge classification and rounded crossing position.
module polygon_line_crossing_winding_top_test;

	localparam int CLK_HALF = 6;
	localparam int SETTLE_CYCLES = 600;   // worst case: four crossings in flight
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic signed [63:0] pos;
		logic signed [25:0] wgt;
		logic               tail;
	} crossing_t;

	logic clk;
	logic arst_n;

	plcw_cfg_if cfg ();
	plcw_vtx_if #(.CW(32)) vtx ();
	plcw_res_if res ();

	polygon_line_crossing_winding_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.vtx(vtx),
		.res(res)
	);

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// shadow copy of the registers and the edge state
	logic [31:0] m_origin_lon, m_origin_lat, m_dir_lon, m_dir_lat;
	logic [1:0]  m_wsign;
	logic signed [63:0] m_prev_al, m_prev_ac, m_first_al, m_first_ac;

	crossing_t pending_events[$];
	int n_fail = 0;

	// idle control for the sender and the result side; calm is shared by both
	bit calm = 0;              // tail of the run: no idling at all
	int hold_req = 0;          // long hold-off on results, in cycles
	int hold_left = 0;
	int res_gap = 0;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------
	// rounded crossing: start.along + trunc((s_ac*diff + trunc(d/2)) / d)
	function automatic logic signed [63:0] crossing_at(logic signed [63:0] s_al,
			logic signed [63:0] s_ac, logic signed [63:0] e_al, logic signed [63:0] e_ac);
		logic signed [63:0]  diff;
		logic signed [65:0]  d;
		logic signed [129:0] num;
		logic signed [129:0] q;
		diff = e_al - s_al;
		d = s_ac;
		d = d - e_ac;
		num = s_ac;
		num = num * diff;
		num = num + d / 66'sd2;
		q = num / d;
		return s_al + q[63:0];
	endfunction

	function automatic void add_event(ref crossing_t evs[$], input logic signed [63:0] pos,
			input logic signed [25:0] w);
		crossing_t c;
		if (evs.size() >= 4)
			return;
		c.pos = pos;
		c.wgt = w;
		c.tail = 1'b0;
		evs.push_back(c);
	endfunction

	function automatic void edge_events(ref crossing_t evs[$], input int dir,
			input logic signed [63:0] s_al, input logic signed [63:0] s_ac,
			input logic signed [63:0] e_al, input logic signed [63:0] e_ac);
		logic signed [25:0] big;
		big = 26'(dir * (1 << plcw_pkg::ONLINE_SHIFT));
		if (s_ac <= 0) begin
			if (e_ac > 0)
				add_event(evs, crossing_at(s_al, s_ac, e_al, e_ac), 26'(dir));
			else if (s_ac == 0 && e_ac == 0) begin
				add_event(evs, s_al, big);
				add_event(evs, e_al, -big);
			end
		end else if (e_ac <= 0) begin
			add_event(evs, crossing_at(s_al, s_ac, e_al, e_ac), 26'(-dir));
		end
	endfunction

	function automatic void predict_vertex(logic [31:0] lon, logic [31:0] lat,
			bit first, bit last);
		crossing_t evs[$];
		crossing_t c;
		logic signed [31:0] pa, pb, a, b;
		logic signed [63:0] al, ac;
		int dir;
		case (m_wsign)
			2'd0: dir = 0;
			2'd1: dir = 1;
			default: dir = -1;   // -2 saturates to -1
		endcase
		a = m_dir_lon;
		b = m_dir_lat;
		pa = lon - m_origin_lon;
		pb = lat - m_origin_lat;
		al = (64'(a) * 64'(pa)) + (64'(b) * 64'(pb));
		ac = (64'(a) * 64'(pb)) - (64'(b) * 64'(pa));
		if (first) begin
			m_first_al = al;
			m_first_ac = ac;
		end else
			edge_events(evs, dir, m_prev_al, m_prev_ac, al, ac);
		m_prev_al = al;
		m_prev_ac = ac;
		if (last) begin
			edge_events(evs, dir, al, ac, m_first_al, m_first_ac);
			if (evs.size() == 0)
				add_event(evs, 64'sd0, 26'sd0);
			evs[evs.size() - 1].tail = 1'b1;
		end
		foreach (evs[i]) begin
			c = evs[i];
			pending_events.push_back(c);
		end
	endfunction

	// ---------------------------------------------------------------
	// result side: ready pattern and checking
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left = 0;
			res_gap = 0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (calm) begin
				res.ready <= 1'b1;
			end else if (res_gap > 0) begin
				res_gap--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					res_gap = $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result pos=%0d wgt=%0d end=%0b",
					res.crossing_pos, res.weight_delta, res.polygon_end);
				n_fail++;
			end else begin
				want = pending_events.pop_front();
				if (res.crossing_pos !== want.pos) begin
					$error("crossing_pos: expected %0d, got %0d", want.pos, res.crossing_pos);
					n_fail++;
				end
				if (res.weight_delta !== want.wgt) begin
					$error("weight_delta: expected %0d, got %0d", want.wgt, res.weight_delta);
					n_fail++;
				end
				if (res.polygon_end !== want.tail) begin
					$error("polygon_end: expected %0b, got %0b", want.tail, res.polygon_end);
					n_fail++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------
	task automatic send_vertex(logic [31:0] lon, logic [31:0] lat, bit first, bit last);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			vtx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx.valid <= 1'b1;
		vtx.vertex_lon <= lon;
		vtx.vertex_lat <= lat;
		vtx.first_vertex <= first;
		vtx.last_vertex <= last;
		do
			@(posedge clk);
		while (!vtx.ready);
		predict_vertex(lon, lat, first, last);
	endtask

	// drop valid after the last transfer of a phase
	task automatic release_vtx();
		vtx.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected event, then let an event-free vertex finish
	task automatic drain();
		release_vtx();
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// valid stays up so writes can follow back to back; end_cfg drops it
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			plcw_pkg::REG_ORIGIN_LON: m_origin_lon = value;
			plcw_pkg::REG_ORIGIN_LAT: m_origin_lat = value;
			plcw_pkg::REG_DIR_LON:    m_dir_lon = value;
			plcw_pkg::REG_DIR_LAT:    m_dir_lat = value;
			plcw_pkg::REG_WIND_SIGN:  m_wsign = value[1:0];
			default: ;      // unmapped index, ignored
		endcase
	endtask

	task automatic end_cfg();
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_line(logic [31:0] olon, logic [31:0] olat, logic [31:0] dlon,
			logic [31:0] dlat, logic [1:0] ws);
		drain();
		write_reg(plcw_pkg::REG_ORIGIN_LON, olon);
		write_reg(plcw_pkg::REG_ORIGIN_LAT, olat);
		write_reg(plcw_pkg::REG_DIR_LON, dlon);
		write_reg(plcw_pkg::REG_DIR_LAT, dlat);
		write_reg(plcw_pkg::REG_WIND_SIGN, {30'd0, ws});
		end_cfg();
	endtask

	// coordinate near the origin most of the time, sometimes exactly at the origin's
	// coordinate, sometimes anywhere in the 32-bit range
	function automatic logic [31:0] pick_coord(logic [31:0] center);
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return center;
			2: return center + $urandom_range(0, 3) - 32'd1;
			default: return center + $urandom_range(0, 2000) - 32'd1000;
		endcase
	endfunction

	task automatic send_polygon(int n);
		for (int i = 0; i < n; i++)
			send_vertex(pick_coord(m_origin_lon), pick_coord(m_origin_lat),
				i == 0, i == n - 1);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// reset values: line along +lon through (0,0); no first vertex yet
	task automatic test_after_reset();
		send_vertex(32'd5, 32'd7, 1'b0, 1'b0);        // edge from stored (0,0): up
		send_vertex(-32'd4, -32'd3, 1'b0, 1'b0);      // down crossing
		send_vertex(32'd9, 32'd0, 1'b1, 1'b1);        // single vertex on the line
		send_vertex(32'd9, 32'd4, 1'b1, 1'b1);        // single vertex off the line
	endtask

	task automatic test_directed();
		// an on-line edge and the closing edge
		send_vertex(32'd1, 32'd0, 1'b1, 1'b0);
		send_vertex(32'd10, 32'd0, 1'b0, 1'b0);
		send_vertex(32'd10, 32'd5, 1'b0, 1'b0);
		send_vertex(-32'd3, -32'd5, 1'b0, 1'b1);
		// field extremes
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
		send_vertex(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
		set_line(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 2'b11);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_vertex(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
		// no weight, and the unused sign code that saturates to -1
		set_line(32'd0, 32'd0, 32'd3, -32'd2, 2'b00);
		send_polygon(3);
		set_line(-32'd100, 32'd50, -32'd1, 32'd1, 2'b10);
		send_polygon(4);
		send_vertex(32'd0, 32'd0, 1'b1, 1'b1);
		// unmapped register index has no effect
		drain();
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		end_cfg();
		send_polygon(3);
	endtask

	task automatic test_random_polygons(int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary flags and coordinates
				send_vertex($urandom(), pick_coord(m_origin_lat), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				n = $urandom_range(1, 5);
				send_polygon(n);
				sent += n;
			end
			if ($urandom_range(0, 14) == 0) begin
				if ($urandom_range(0, 1))
					set_line($urandom(), $urandom(), $urandom(), $urandom(),
						2'($urandom_range(0, 3)));
				else
					set_line($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
						$urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
						2'($urandom_range(0, 3)));
			end
		end
	endtask

	// results held back while vertices keep coming, so the input stalls
	task automatic test_backpressure();
		set_line(32'd0, 32'd0, 32'd1, 32'd0, 2'b01);
		hold_req = 3000;
		for (int i = 0; i < 12; i++)
			send_vertex($urandom_range(0, 100), i[0] ? 32'd40 : -32'd40, i == 0, i == 11);
	endtask

	// sender waits for every result before going on
	task automatic test_drain_pause();
		send_polygon(4);
		drain();
		send_polygon(3);
	endtask

	task automatic test_calm_tail();
		drain();
		calm = 1;
		test_random_polygons(25);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = plcw_pkg::REG_ORIGIN_LON;
		cfg.data = '0;
		vtx.valid = 1'b0;
		vtx.vertex_lon = '0;
		vtx.vertex_lat = '0;
		vtx.first_vertex = 1'b0;
		vtx.last_vertex = 1'b0;
		m_origin_lon = '0;
		m_origin_lat = '0;
		m_dir_lon = 32'd1;
		m_dir_lat = '0;
		m_wsign = 2'b01;
		m_prev_al = '0;
		m_prev_ac = '0;
		m_first_al = '0;
		m_first_ac = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_directed();
		test_random_polygons(100);
		test_backpressure();
		test_drain_pause();
		test_calm_tail();
		drain();

		if (n_fail == 0)
			$display("polygon_line_crossing_winding_top regression: pass");
		else
			$display("polygon_line_crossing_winding_top regression: fail");
		$finish;
	end

	initial begin
		#(64'd40_000_000);
		$display("polygon_line_crossing_winding_top regression: fail");
		$finish;
	end
endmodule
